// ----- design/asmrp_pkg.sv -----
// Shared widths, register indexes, phase codes and helpers for the start-up mute ramp block.
`timescale 1ns / 1ps
`default_nettype none
package asmrp_pkg;

  // Field and state widths
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned PEAK_W    = 15;
  localparam int unsigned PHASE_W   = 2;
  localparam int unsigned CFG_W     = 24;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned POS_W     = 32;

  // Default gain fraction bits (valid range 8 to 16)
  localparam int unsigned GAIN_FRAC_BITS_DEF = 14;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MUTE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP = 1'd1;

  typedef logic [PHASE_W-1:0] phase_t;

  // Phase codes reported with each item
  localparam phase_t PHASE_MUTE = 2'd0;
  localparam phase_t PHASE_RAMP = 2'd1;
  localparam phase_t PHASE_PASS = 2'd2;

  // Absolute value of a sample, most negative value saturates to full scale
  function automatic logic [PEAK_W-1:0] sat_abs(input logic signed [SAMPLE_W-1:0] v);
    logic [SAMPLE_W-1:0] neg;
    neg = SAMPLE_W'(-v);
    if (v == {1'b1, {(SAMPLE_W-1){1'b0}}}) begin
      return {PEAK_W{1'b1}};
    end else if (v[SAMPLE_W-1]) begin
      return neg[PEAK_W-1:0];
    end else begin
      return v[PEAK_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// ----- design/asmrp_div.sv -----
// Bit-serial restoring divider that forms the ramp gain one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module asmrp_div #(
  parameter int unsigned FRAC_BITS = asmrp_pkg::GAIN_FRAC_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [asmrp_pkg::CFG_W-1:0]  num_i,
  input  wire logic [asmrp_pkg::CFG_W-1:0]  den_i,
  output logic                              done_o,
  output logic [FRAC_BITS-1:0]              quot_o
);
  import asmrp_pkg::*;

  localparam int unsigned CNT_W = $clog2(FRAC_BITS + 1);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic [CFG_W-1:0] rem_q;
  logic [CFG_W-1:0] den_q;
  logic [FRAC_BITS-1:0] quot_q;

  logic [CFG_W:0]   rem_sh;
  logic [CFG_W+1:0] diff;
  logic             ge;

  // Shift the partial remainder and try one subtract
  always_comb begin
    rem_sh = {rem_q, 1'b0};
    diff   = {1'b0, rem_sh} - {2'b00, den_q};
    ge     = ~diff[CFG_W+1];
  end

  // Sequence the iterations
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(FRAC_BITS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Hold operands and develop the quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_i;
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[CFG_W-1:0] : rem_sh[CFG_W-1:0];
      quot_q <= {quot_q[FRAC_BITS-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule
`default_nettype wire

// ----- design/audio_startup_mute_ramp_peak.sv -----
// Top level: start-up mute, linear fade-in and peak meter on a PCM sample stream.
//
// Usage: one signed 16-bit sample enters per item on the in channel (valid/ready),
// with a restart_peak flag. Each item yields one result on the out channel:
// the output sample, the peak level including it, and the phase (mute, ramp, pass).
// Two registers are written on the cfg channel, index 0 mute length, index 1
// ramp length, both in samples; the user must write them only while the block is
// idle, as the block itself does not enforce this. An accepted item passes the
// evaluate and check steps; an item in the ramp span then waits while the serial
// gain divider forms its gain, one quotient bit per cycle, and takes a multiply
// step. Every item ends in the finish step; the result appears in the output
// register when the item finishes and ready returns at once.
// Reset clears the sample position, peak hold and output valid; mute length
// resets to 0 and ramp length to 1.
// A stalled receiver holds the result in the output register; the next item is
// still taken and worked on, and waits in its last step until that register frees.
`timescale 1ns / 1ps
`default_nettype none
module audio_startup_mute_ramp_peak #(
  parameter int unsigned GAIN_FRAC_BITS = asmrp_pkg::GAIN_FRAC_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Configuration writes
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [asmrp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [asmrp_pkg::CFG_W-1:0]      cfg_data_i,
  // Sample input
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic signed [asmrp_pkg::SAMPLE_W-1:0] sample_in_i,
  input  wire logic                             restart_peak_i,
  // Result output
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic signed [asmrp_pkg::SAMPLE_W-1:0] sample_out_o,
  output logic [asmrp_pkg::PEAK_W-1:0]          peak_level_o,
  output logic [asmrp_pkg::PHASE_W-1:0]         phase_o
);
  import asmrp_pkg::*;

  localparam int unsigned PROD_W = SAMPLE_W + GAIN_FRAC_BITS + 1;

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EVAL = 3'd1;
  localparam logic [2:0] ST_CHK  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0] state_q, state_d;

  logic [CFG_W-1:0] mute_q;
  logic [CFG_W-1:0] ramp_q;
  logic [POS_W-1:0] pos_q;
  logic [PEAK_W-1:0] peak_q;

  logic signed [SAMPLE_W-1:0] sample_q;
  logic                       restart_q;
  logic [POS_W-1:0]           rel_q;
  logic                       muted_q;
  phase_t                     phase_q;
  logic signed [PROD_W-1:0]   prod_q;

  logic                        out_valid_q;
  logic signed [SAMPLE_W-1:0]  sample_out_q;
  logic [PEAK_W-1:0]           peak_out_q;
  phase_t                      phase_out_q;

  logic [POS_W:0]       rel_full;
  logic                 in_ramp;
  logic                 div_start;
  logic [CFG_W-1:0]     div_num;
  logic                 div_done;
  logic [GAIN_FRAC_BITS-1:0] div_quot;
  logic                 out_free;
  logic signed [SAMPLE_W-1:0] y;
  logic [PEAK_W-1:0]    y_mag;
  logic [PEAK_W-1:0]    peak_new;
  logic [PEAK_W-1:0]    abs_out;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_free    = ~out_valid_q | out_ready_i;

  // Relative position and ramp span test
  assign rel_full = {1'b0, pos_q} - {{(POS_W-CFG_W+1){1'b0}}, mute_q};
  assign in_ramp  = (ramp_q != '0) && (rel_q[POS_W-1:CFG_W] == '0) &&
                    (rel_q[CFG_W-1:0] < ramp_q);

  // Start the divider on the step-aligned relative position
  assign div_start = (state_q == ST_CHK) && !muted_q && in_ramp;
  assign div_num   = {rel_q[CFG_W-1:2], 2'b00};

  asmrp_div #(
    .FRAC_BITS (GAIN_FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (ramp_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Select the output sample for the phase and update the peak
  always_comb begin
    case (phase_q)
      PHASE_MUTE: y = '0;
      PHASE_RAMP: y = prod_q[GAIN_FRAC_BITS+SAMPLE_W-1:GAIN_FRAC_BITS];
      default:    y = sample_q;
    endcase
    y_mag    = sat_abs(y);
    peak_new = (y_mag > peak_q) ? y_mag : peak_q;
  end

  // Advance the sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_EVAL;
      ST_EVAL: state_d = ST_CHK;
      ST_CHK: begin
        state_d = div_start ? ST_DIV : ST_FIN;
      end
      ST_DIV: if (div_done) state_d = ST_MUL;
      ST_MUL: state_d = ST_FIN;
      ST_FIN: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state, configuration, position and peak
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mute_q      <= '0;
      ramp_q      <= CFG_W'(1);
      pos_q       <= '0;
      peak_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_MUTE: mute_q <= cfg_data_i;
          REG_RAMP: ramp_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == ST_EVAL && pos_q != {POS_W{1'b1}}) begin
        pos_q <= pos_q + POS_W'(1);
      end
      if (state_q == ST_FIN && out_free) begin
        peak_q      <= restart_q ? '0 : peak_new;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item datapath registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      sample_q  <= sample_in_i;
      restart_q <= restart_peak_i;
    end
    if (state_q == ST_EVAL) begin
      rel_q   <= rel_full[POS_W-1:0];
      muted_q <= rel_full[POS_W];
    end
    if (state_q == ST_CHK) begin
      if (muted_q) begin
        phase_q <= PHASE_MUTE;
      end else if (in_ramp) begin
        phase_q <= PHASE_RAMP;
      end else begin
        phase_q <= PHASE_PASS;
      end
    end
    if (state_q == ST_MUL) begin
      prod_q <= sample_q * $signed({1'b0, div_quot});
    end
    if (state_q == ST_FIN && out_free) begin
      sample_out_q <= y;
      peak_out_q   <= peak_new;
      phase_out_q  <= phase_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_out_q;
  assign peak_level_o = peak_out_q;
  assign phase_o      = phase_out_q;

  assign abs_out = sat_abs(sample_out_q);

  // Reported peak covers the reported sample
  a_peak_covers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (peak_level_o >= abs_out))
    else $error("peak level below output magnitude");

  // Muted items come out as silence
  a_mute_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && phase_o == PHASE_MUTE) |-> (sample_out_o == '0))
    else $error("muted item is not zero");

  // Divider finishes only while the sequencer waits on it
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider done outside divide step");

  // Position saturates at its maximum
  a_pos_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q == {POS_W{1'b1}}) |=> (pos_q == {POS_W{1'b1}}))
    else $error("position counter wrapped");

endmodule
`default_nettype wire

// ----- test/tb_audio_startup_mute_ramp_peak.sv -----
// Testbench for the start-up mute, fade-in ramp and peak meter block.
`timescale 1ns / 1ps
module tb_audio_startup_mute_ramp_peak;
  import asmrp_pkg::*;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic [PEAK_W-1:0]          peak;
    phase_t                     phase;
  } fade_result_t;

  // Track position, gain and peak hold; queue the result each sample should give
  class fade_peak_tracker;
    logic [POS_W-1:0]  position;
    logic [CFG_W-1:0]  mute_len;
    logic [CFG_W-1:0]  ramp_len;
    logic [15:0]       ramp_gain;
    logic [PEAK_W-1:0] peak_hold;
    fade_result_t      pending_results[$];
    int unsigned       failures;

    function new();
      position  = '0;
      mute_len  = '0;
      ramp_len  = CFG_W'(1);
      ramp_gain = '0;
      peak_hold = '0;
      failures  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      if (idx == REG_MUTE) begin
        mute_len = value;
      end else if (idx == REG_RAMP) begin
        ramp_len = value;
      end
    endfunction

    function void note_sample(logic signed [SAMPLE_W-1:0] s, logic restart);
      fade_result_t        res;
      logic [POS_W-1:0]    offset;
      logic [63:0]         quotient;
      longint              scaled;
      logic [SAMPLE_W-1:0] neg;
      logic [PEAK_W-1:0]   mag;
      offset = position - POS_W'(mute_len);
      if (position < POS_W'(mute_len)) begin
        res.phase  = PHASE_MUTE;
        res.sample = '0;
      end else if (ramp_len != 0 && offset < POS_W'(ramp_len)) begin
        // gain steps every four samples; shift rounds toward minus infinity
        res.phase = PHASE_RAMP;
        quotient  = ({32'd0, offset & ~32'd3} << GAIN_FRAC_BITS_DEF) / {40'd0, ramp_len};
        ramp_gain = quotient[15:0];
        scaled    = (longint'(s) * longint'(ramp_gain)) >>> GAIN_FRAC_BITS_DEF;
        res.sample = scaled[SAMPLE_W-1:0];
      end else begin
        res.phase  = PHASE_PASS;
        res.sample = s;
      end
      if (position != '1) begin
        position++;
      end
      // full-scale negative saturates to the largest positive magnitude
      neg = -res.sample;
      if (res.sample == 16'sh8000) begin
        mag = '1;
      end else if (res.sample < 0) begin
        mag = neg[PEAK_W-1:0];
      end else begin
        mag = res.sample[PEAK_W-1:0];
      end
      if (mag > peak_hold) begin
        peak_hold = mag;
      end
      res.peak = peak_hold;
      pending_results.insert(pending_results.size(), res);
      if (restart) begin
        peak_hold = '0;
      end
    endfunction

    function void check_result(logic signed [SAMPLE_W-1:0] sample,
                               logic [PEAK_W-1:0] peak, phase_t ph);
      fade_result_t exp_res;
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing pending: sample_out %0d peak %0d phase %0d",
                 $time, sample, peak, ph);
        failures++;
        return;
      end
      exp_res = pending_results.pop_front();
      if (sample !== exp_res.sample) begin
        $display("%0t: sample_out expected %0d, got %0d", $time, exp_res.sample, sample);
        failures++;
      end
      if (peak !== exp_res.peak) begin
        $display("%0t: peak_level expected %0d, got %0d", $time, exp_res.peak, peak);
        failures++;
      end
      if (ph !== exp_res.phase) begin
        $display("%0t: phase expected %0d, got %0d", $time, exp_res.phase, ph);
        failures++;
      end
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [CFG_W-1:0]            cfg_data = '0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic signed [SAMPLE_W-1:0]  sample_in = '0;
  logic                        restart_peak = 1'b0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0]  sample_out;
  logic [PEAK_W-1:0]           peak_level;
  logic [PHASE_W-1:0]          phase_out;

  fade_peak_tracker fade = new();
  int unsigned      samples_sent = 0;
  int unsigned      rx_hold_cycles = 0;

  audio_startup_mute_ramp_peak uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .sample_in_i    (sample_in),
    .restart_peak_i (restart_peak),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .sample_out_o   (sample_out),
    .peak_level_o   (peak_level),
    .phase_o        (phase_out)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("audio_startup_mute_ramp_peak regression: fail");
    $finish;
  end

  // Mostly no gap, sometimes a short one, rarely a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      return 0;
    end else if (roll < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Bias toward full-scale and near-zero samples
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'shFFFF;
      3: return 16'sh0001;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Offer one item and hold it until accepted; drop valid only for a gap
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic rs,
                             input int unsigned gap);
    in_valid     <= 1'b1;
    sample_in    <= s;
    restart_peak <= rs;
    do @(posedge clk); while (!in_ready);
    fade.note_sample(s, rs);
    samples_sent++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    fade.write_reg(idx, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stop offering items and wait until every result is back, plus the item latency
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (fade.pending_results.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic set_span(input logic [CFG_W-1:0] mute_v, input logic [CFG_W-1:0] ramp_v);
    wait_idle();
    write_reg(REG_MUTE, mute_v);
    write_reg(REG_RAMP, ramp_v);
  endtask

  // Receiver: random stalls, ready stretches, and a long hold-off on request
  initial begin : receiver
    int unsigned n;
    forever begin
      if (rx_hold_cycles != 0) begin
        n = rx_hold_cycles;
        rx_hold_cycles = 0;
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(20, 60)) @(posedge clk);
      end else begin
        n = pick_gap();
        if (n != 0) begin
          out_ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      fade.check_result(sample_out, peak_level, phase_out);
    end
  end

  initial begin : stimulus
    logic signed [SAMPLE_W-1:0] dir_samples [16];
    logic [15:0]                dir_restart;
    logic [CFG_W-1:0]           mute_v;
    logic [CFG_W-1:0]           ramp_v;
    int unsigned                ph;
    int unsigned                n;
    int unsigned                count;
    bit                         pressure;
    // two muted, eight ramped (gain zero then one half), six passed
    dir_samples = '{16'sh7FFF, 16'sh8000,
                    16'sh7FFF, 16'sh8000, 16'shFFFF, 16'sh0001,
                    16'sh7FFF, 16'sh8000, 16'shFFFF, 16'sh3039,
                    16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF,
                    16'sh4000, 16'shC000};
    dir_restart = 16'b0010_1000_0100_0010;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset registers: one ramp sample at zero gain, then pass-through
    send_sample(16'sh1234, 1'b0, pick_gap());
    send_sample(16'sh8000, 1'b1, pick_gap());

    set_span(CFG_W'(fade.position + 2), CFG_W'(8));
    for (n = 0; n < 16; n++) begin
      send_sample(dir_samples[n], dir_restart[n], pick_gap());
    end

    // zero ramp length: straight from mute to pass-through
    set_span(CFG_W'(fade.position + 1), '0);
    repeat (3) send_sample(pick_sample(), 1'b0, pick_gap());

    for (ph = 0; samples_sent < 600; ph++) begin
      pressure = (ph == 2);
      case (ph)
        0: begin
          mute_v = '1;
          ramp_v = '1;
        end
        1: begin
          mute_v = '0;
          ramp_v = '1;
        end
        2: begin
          mute_v = CFG_W'(fade.position + 3);
          ramp_v = CFG_W'(24);
        end
        3: begin
          mute_v = '0;
          ramp_v = CFG_W'(1);
        end
        default: begin
          case ($urandom_range(0, 5))
            0: begin
              mute_v = CFG_W'(fade.position + $urandom_range(0, 8));
              ramp_v = '0;
            end
            1: begin
              // long ramp already under way: large, nonzero gains
              mute_v = '0;
              ramp_v = CFG_W'(fade.position + $urandom_range(1, 2000));
            end
            default: begin
              mute_v = CFG_W'(fade.position + $urandom_range(0, 8));
              ramp_v = CFG_W'($urandom_range(1, 48));
            end
          endcase
        end
      endcase
      set_span(mute_v, ramp_v);
      count = pressure ? 40 : $urandom_range(10, 40);
      // receiver stalls while items keep coming, so the input backs up
      if (pressure) begin
        rx_hold_cycles = 300;
      end
      for (n = 0; n < count; n++) begin
        send_sample(pick_sample(), $urandom_range(0, 7) == 0, pressure ? 0 : pick_gap());
      end
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (fade.failures == 0) begin
      $display("audio_startup_mute_ramp_peak regression: pass");
    end else begin
      $display("audio_startup_mute_ramp_peak regression: fail");
    end
    $finish;
  end

endmodule
